@@ sv/row_argmax_argmin_assert.svh @@
// Assertion macros for the row arg-reduction block.
`ifndef ROW_ARGMAX_ARGMIN_ASSERT_SVH
`define ROW_ARGMAX_ARGMIN_ASSERT_SVH
`ifndef SYNTHESIS
`define RAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RAM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RAM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/ram_pkg.sv @@
// ----------------------------------------------------------------------------
// ram_pkg
// Types and constants for the row arg-reduction block.
// ----------------------------------------------------------------------------
package ram_pkg;

	typedef struct packed {
		logic [31:0] sample_bits;
		logic        last_in_row;
	} in_item_t;

	typedef struct packed {
		logic [15:0] winner_index;
		logic        length_overflow;
	} out_item_t;

	localparam logic       CFG_SELECT_MINIMUM = 1'b0;
	localparam logic       CFG_VALUE_FORMAT   = 1'b1;
	localparam logic [1:0] FMT_F32  = 2'd0;
	localparam logic [1:0] FMT_F16  = 2'd1;
	localparam logic [1:0] FMT_BF16 = 2'd2;
	localparam logic [31:0] POS_INF = 32'h7F80_0000;
	localparam logic [31:0] NEG_INF = 32'hFF80_0000;

endpackage

@@ sv/ram_decode.sv @@
// ----------------------------------------------------------------------------
// ram_decode
// Widens an f32, f16 or bf16 sample to f32 bits (exact).
// ----------------------------------------------------------------------------
module ram_decode (
	input  logic [1:0]  value_format,
	input  logic [31:0] raw,
	output logic [31:0] f32
);
	logic [4:0]  h_exp;
	logic [9:0]  h_man;
	logic [9:0]  sub_man;
	logic [7:0]  sub_exp;
	logic [31:0] half_w;

	assign h_exp = raw[14:10];
	assign h_man = raw[9:0];

	// subnormal normalize: find leading one of a 10-bit mantissa
	always_comb begin
		sub_man = h_man;
		sub_exp = 8'd112;
		for (int i = 0; i < 10; i++) begin
			if (!sub_man[9]) begin
				sub_man = {sub_man[8:0], 1'b0};
				sub_exp = sub_exp - 8'd1;
			end
		end
		// leading one now at bit 9 shifted out as hidden bit
		sub_man = {sub_man[8:0], 1'b0};
	end

	always_comb begin
		if (h_exp == 5'd0) begin
			if (h_man == 10'd0) half_w = {raw[15], 31'd0};
			else half_w = {raw[15], sub_exp, sub_man, 13'd0};
		end else if (h_exp == 5'd31) begin
			half_w = {raw[15], 8'hFF, h_man, 13'd0};
		end else begin
			half_w = {raw[15], 8'({3'd0, h_exp} + 8'd112), h_man, 13'd0};
		end
	end

	always_comb begin
		unique case (value_format)
			ram_pkg::FMT_F16:  f32 = half_w;
			ram_pkg::FMT_BF16: f32 = {raw[15:0], 16'd0};
			default:           f32 = raw;
		endcase
	end
endmodule

@@ sv/row_argmax_argmin.sv @@
// Result: registered in the output register, valid in the cycle after the last item of a row is accepted.
// Throughput: one item per cycle unless in_stall holds it; the decode, float compare and select are combinational.
// The output register parts the sides: input accepted while a result waits if it is
// taken this cycle or the item is not last in its row.
// Reset: async active low; min mode off, f32 format, row state cleared to -inf.
// ----------------------------------------------------------------------------
// row_argmax_argmin
// Streaming argmax / argmin over rows of float samples, first occurrence wins.
// ----------------------------------------------------------------------------
`include "row_argmax_argmin_assert.svh"
module row_argmax_argmin #(
	parameter longint MAX_ROW_LENGTH = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ram_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ram_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [1:0]          cfg_data
);
	localparam longint LIM = (MAX_ROW_LENGTH > 65536) ? 65536 : MAX_ROW_LENGTH;
	localparam logic [16:0] LIM_C = 17'(LIM);
	localparam logic [15:0] LAST_POS = 16'(LIM - 1);

	logic        sel_min_q;
	logic [1:0]  fmt_q;
	logic [31:0] best_q;
	logic [15:0] best_pos_q;
	logic [16:0] count_q;
	logic        ovf_q;
	logic [31:0] v;
	logic        accept, better, v_nan, b_nan, gt, lt, cfg_wr, at_lim;
	logic [15:0] pos;
	logic [31:0] ov, ob;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign in_stall = out_valid && out_stall && in_data.last_in_row;
	assign accept = in_valid && !in_stall;

	ram_decode u_dec (.value_format(fmt_q), .raw(in_data.sample_bits), .f32(v));

	// ordered compare through sign-magnitude to ordinal mapping; -0 equals +0
	assign v_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	assign b_nan = (best_q[30:23] == 8'hFF) && (best_q[22:0] != 23'd0);
	assign ov = v[31] ? ~v : (v[30:0] == 31'd0 ? 32'h8000_0000 : {1'b1, v[30:0]});
	assign ob = best_q[31] ? ~best_q
		: (best_q[30:0] == 31'd0 ? 32'h8000_0000 : {1'b1, best_q[30:0]});
	assign gt = (ov > ob) && !(v[30:0] == 31'd0 && best_q[30:0] == 31'd0);
	assign lt = (ov < ob) && !(v[30:0] == 31'd0 && best_q[30:0] == 31'd0);
	assign better = !v_nan && !b_nan && (sel_min_q ? lt : gt);

	assign at_lim = (count_q >= LIM_C);
	assign pos = at_lim ? LAST_POS : count_q[15:0];

	// config and row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_min_q  <= 1'b0;
			fmt_q      <= ram_pkg::FMT_F32;
			best_q     <= ram_pkg::NEG_INF;
			best_pos_q <= '0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
		end else if (cfg_wr && cfg_index == ram_pkg::CFG_SELECT_MINIMUM) begin
			sel_min_q  <= cfg_data[0];
			best_q     <= cfg_data[0] ? ram_pkg::POS_INF : ram_pkg::NEG_INF;
			best_pos_q <= '0;
			count_q    <= '0;
			ovf_q      <= 1'b0;
		end else begin
			if (cfg_wr && cfg_index == ram_pkg::CFG_VALUE_FORMAT) fmt_q <= cfg_data;
			if (accept) begin
				if (in_data.last_in_row) begin
					best_q     <= sel_min_q ? ram_pkg::POS_INF : ram_pkg::NEG_INF;
					best_pos_q <= '0;
					count_q    <= '0;
					ovf_q      <= 1'b0;
				end else begin
					if (better) begin
						best_q     <= v;
						best_pos_q <= pos;
					end
					if (at_lim) ovf_q <= 1'b1;
					else count_q <= count_q + 17'd1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept && in_data.last_in_row) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.last_in_row) begin
			out_data.winner_index    <= better ? pos : best_pos_q;
			out_data.length_overflow <= ovf_q || at_lim;
		end
	end

	`RAM_ASSERT_IMP(a_no_accept_over_result, clk, arst_n, out_valid && out_stall && in_valid && in_data.last_in_row, in_stall)
	`RAM_ASSERT_NEXT(a_result_after_last, clk, arst_n, accept && in_data.last_in_row, out_valid)
	`RAM_ASSERT_IMP(a_count_bounded, clk, arst_n, 1'b1, count_q <= LIM_C)
endmodule
